>>> rtl/core/pngc2pa_pkg.sv
// shared types and constants for the png credential chunk extractor
// no dependencies; imported by the record queue and the top level

package pngc2pa_pkg;

  // parse phases of the chunk walker
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_BODY = 3'd3,
    PH_DONE = 3'd4,
    PH_FAIL = 3'd5
  } phase_t;

  // final stream status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SIG = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_NO_IEND = 2'd3
  } status_t;

  localparam logic REC_CHUNK  = 1'b0;
  localparam logic REC_STATUS = 1'b1;
  localparam logic CAR_CABX   = 1'b0;
  localparam logic CAR_ITXT   = 1'b1;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] chunk_offset;
    logic [31:0] data_length;
    logic        carrier_kind;
    status_t     status;
    logic        last_result;
  } rec_t;

  localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

  localparam logic [31:0] TYPE_CABX = "caBX";
  localparam logic [31:0] TYPE_ITXT = "iTXt";
  localparam logic [31:0] TYPE_IEND = "IEND";

  // tokens, last character in the low byte
  localparam logic [23:0]  TOK_CR = "cr:";
  localparam logic [55:0]  TOK_XP = "xpacket";
  localparam logic [103:0] TOK_AD = "adobe.com/xap";
  localparam logic [87:0]  TOK_CA = "contentauth";

  localparam int WIN_BYTES = 13;
  localparam int WIN_W     = 8 * WIN_BYTES;
  localparam int REM_W     = 33;
  localparam int MIN_BYTES = 20;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

>>> rtl/core/pngc2pa_if.sv
// request channel interfaces for the png credential chunk extractor
// no package dependencies; the status field is a plain two-bit vector

interface pngc2pa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface pngc2pa_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [31:0] chunk_offset;
  logic [31:0] data_length;
  logic        carrier_kind;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output record_kind, output chunk_offset,
                  output data_length, output carrier_kind, output status,
                  output last_result, input ready);
  modport sink   (input valid, input record_kind, input chunk_offset,
                  input data_length, input carrier_kind, input status,
                  input last_result, output ready);
endinterface

>>> rtl/core/pngc2pa_rec_fifo.sv
// result queue: takes zero, one or two records a cycle, hands out one
// depends on pngc2pa_pkg and pngc2pa_out_if

module pngc2pa_rec_fifo import pngc2pa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  rec_t                 rec0,
  input  rec_t                 rec1,
  output logic [Q_CNT_W-1:0]   count,
  pngc2pa_out_if.source        out_ch
);

  rec_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               pop;
  rec_t               head;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    wptr_nxt = wptr_r + Q_PTR_W'(push_n);
    rptr_nxt = rptr_r + Q_PTR_W'(pop);
    cnt_nxt  = cnt_r + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wptr_r] <= rec0;
    end
    if (push_n == 2'd2) begin
      mem_r[wptr_r + Q_PTR_W'(1)] <= rec1;
    end
  end

  assign head  = mem_r[rptr_r];
  assign count = cnt_r;

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.record_kind  = head.record_kind;
  assign out_ch.chunk_offset = head.chunk_offset;
  assign out_ch.data_length  = head.data_length;
  assign out_ch.carrier_kind = head.carrier_kind;
  assign out_ch.status       = head.status;
  assign out_ch.last_result  = head.last_result;

endmodule

>>> rtl/core/png_c2pa_chunk_extractor_unit.sv
// png credential chunk extractor, top level: byte parser and result queue
// depends on pngc2pa_pkg, pngc2pa_if and pngc2pa_rec_fifo
//
// usage
//   in_ch takes one file byte per request; end_of_stream marks the last byte
//   of a file. the next byte after it starts a new file
//   out_ch gives one record per request: a chunk record (caBX, or iTXt with
//   credential xmp) when such a chunk ends, and one status record with
//   last_result set after the final byte of each file
//   a nonzero status tells the consumer to drop that file's chunk records
// timing
//   one byte per cycle sustained while in_ch.ready stays high; a byte is parsed
//   while it sits in the input register, the cycle after its request, and its
//   records are written into the record queue and show on out_ch at its head
//   the parse path is one byte compare set, a 33-bit decrement and the
//   window token compares, all in parallel
// reset and stalls
//   reset returns the parser to the signature phase with an empty queue
//   records wait in an 8-entry queue while out_ch stalls; in_ch.ready drops
//   once the queue could not absorb the worst case of the bytes in flight

module png_c2pa_chunk_extractor_unit import pngc2pa_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  pngc2pa_in_if.sink    in_ch,
  pngc2pa_out_if.source out_ch
);

  // input register
  logic       s_valid_r;
  logic [7:0] s_byte_r;
  logic       s_eos_r;
  logic       in_acc;

  // parser state
  phase_t              phase_r, phase_nxt;
  logic [3:0]          fc_r, fc_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] cstart_r, cstart_nxt;
  logic [31:0]         len_r, len_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [31:0]         type_r, type_nxt;
  logic [WIN_W-1:0]    win_r, win_nxt;
  logic [3:0]          tok_r, tok_nxt;
  logic                min_r, min_nxt;

  // scan datapath
  logic             chunk_open;
  logic [WIN_W-1:0] win_scan;
  logic [3:0]       tok_scan;
  logic [REM_W-1:0] rem_dec;
  logic             body_done;
  logic             is_cabx;
  logic             is_itxt;
  logic             stream_end;

  // records
  logic [1:0]         push_n;
  rec_t               rec0, rec1, chunk_rec, stat_rec;
  status_t            stat;
  logic [Q_CNT_W-1:0] q_count;

  // room for two records from the byte in parse plus two from a new byte
  assign in_ch.ready = (32'(q_count) + (s_valid_r ? 32'd2 : 32'd0)) <= (Q_DEPTH - 2);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_byte_r <= in_ch.byte_value;
      s_eos_r  <= in_ch.end_of_stream;
    end
  end

  assign stream_end = s_valid_r && s_eos_r;

  // window scan: cleared at the first length byte of every chunk
  assign chunk_open = (phase_r == PH_LEN) && (fc_r == 4'd0);
  assign win_scan   = {(chunk_open ? {(WIN_W-8){1'b0}} : win_r[WIN_W-9:0]), s_byte_r};
  always_comb begin
    tok_scan    = chunk_open ? 4'd0 : tok_r;
    tok_scan[0] = tok_scan[0] | (win_scan[23:0] == TOK_CR);
    tok_scan[1] = tok_scan[1] | (win_scan[55:0] == TOK_XP);
    tok_scan[2] = tok_scan[2] | (win_scan[103:0] == TOK_AD);
    tok_scan[3] = tok_scan[3] | (win_scan[87:0] == TOK_CA);
  end

  assign rem_dec   = rem_r - REM_W'(1);
  assign body_done = s_valid_r && (phase_r == PH_BODY) && (rem_dec == '0);
  assign is_cabx   = (type_r == TYPE_CABX);
  assign is_itxt   = (type_r == TYPE_ITXT) && tok_scan[0] && (|tok_scan[3:1]);

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (s_valid_r) begin
      unique case (phase_r)
        PH_SIG: begin
          if (s_byte_r != SIG_BYTES[fc_r[2:0]]) begin
            phase_nxt = PH_FAIL;
          end else if (fc_r == 4'd7) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (fc_r == 4'd3) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (fc_r == 4'd3) begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (rem_dec == '0) begin
            phase_nxt = (type_r == TYPE_IEND) ? PH_DONE : PH_LEN;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // field counters and captured fields
  always_comb begin
    fc_nxt     = fc_r;
    pos_nxt    = pos_r;
    cstart_nxt = cstart_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    type_nxt   = type_r;
    win_nxt    = win_r;
    tok_nxt    = tok_r;
    min_nxt    = min_r;
    if (s_valid_r) begin
      min_nxt = min_r | (pos_r >= POS_BITS'(MIN_BYTES - 1));
      pos_nxt = pos_r + POS_BITS'(1);
      unique case (phase_r)
        PH_SIG: begin
          if (s_byte_r == SIG_BYTES[fc_r[2:0]]) begin
            fc_nxt = (fc_r == 4'd7) ? 4'd0 : fc_r + 4'd1;
          end
        end
        PH_LEN: begin
          win_nxt = win_scan;
          tok_nxt = tok_scan;
          if (chunk_open) begin
            cstart_nxt = pos_r;
          end
          len_nxt = {(chunk_open ? 24'd0 : len_r[23:0]), s_byte_r};
          fc_nxt  = (fc_r == 4'd3) ? 4'd0 : fc_r + 4'd1;
        end
        PH_TYPE: begin
          win_nxt  = win_scan;
          tok_nxt  = tok_scan;
          type_nxt = {type_r[23:0], s_byte_r};
          if (fc_r == 4'd3) begin
            fc_nxt  = 4'd0;
            rem_nxt = {1'b0, len_r} + REM_W'(4);
          end else begin
            fc_nxt = fc_r + 4'd1;
          end
        end
        PH_BODY: begin
          win_nxt = win_scan;
          tok_nxt = tok_scan;
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            fc_nxt = 4'd0;
          end
        end
        default: fc_nxt = fc_r;
      endcase
    end
  end

  // status after this byte, before the stream-end reset
  always_comb begin
    if (!min_nxt || (phase_nxt == PH_FAIL)) begin
      stat = ST_BAD_SIG;
    end else if (phase_nxt == PH_DONE) begin
      stat = ST_OK;
    end else if (phase_nxt == PH_BODY) begin
      stat = ST_TRUNC;
    end else begin
      stat = ST_NO_IEND;
    end
  end

  // record outputs; a chunk record goes ahead of the status record
  always_comb begin
    chunk_rec.record_kind  = REC_CHUNK;
    chunk_rec.chunk_offset = 32'(cstart_r);
    chunk_rec.data_length  = len_r;
    chunk_rec.carrier_kind = is_itxt ? CAR_ITXT : CAR_CABX;
    chunk_rec.status       = ST_OK;
    chunk_rec.last_result  = 1'b0;

    stat_rec.record_kind  = REC_STATUS;
    stat_rec.chunk_offset = 32'd0;
    stat_rec.data_length  = 32'd0;
    stat_rec.carrier_kind = CAR_CABX;
    stat_rec.status       = stat;
    stat_rec.last_result  = 1'b1;

    if (body_done && (is_cabx || is_itxt)) begin
      rec0   = chunk_rec;
      rec1   = stat_rec;
      push_n = stream_end ? 2'd2 : 2'd1;
    end else begin
      rec0   = stat_rec;
      rec1   = stat_rec;
      push_n = stream_end ? 2'd1 : 2'd0;
    end
  end

  // state registers; the end of a stream returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || stream_end) begin
      phase_r  <= PH_SIG;
      fc_r     <= '0;
      pos_r    <= '0;
      cstart_r <= '0;
      len_r    <= '0;
      rem_r    <= '0;
      type_r   <= '0;
      win_r    <= '0;
      tok_r    <= '0;
      min_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fc_r     <= fc_nxt;
      pos_r    <= pos_nxt;
      cstart_r <= cstart_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      type_r   <= type_nxt;
      win_r    <= win_nxt;
      tok_r    <= tok_nxt;
      min_r    <= min_nxt;
    end
  end

  pngc2pa_rec_fifo u_rec_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .rec0   (rec0),
    .rec1   (rec1),
    .count  (q_count),
    .out_ch (out_ch)
  );

  // queue never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_count) <= Q_DEPTH)
    else $error("record queue overflow");

  // the final byte of a stream always yields a status record, placed last
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    stream_end |-> (push_n != 2'd0) &&
                   ((push_n == 2'd2) ? rec1.last_result : rec0.last_result))
    else $error("stream end without final status record");

  // a new stream starts in the signature phase
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    stream_end |=> (phase_r == PH_SIG) && (pos_r == '0))
    else $error("parser not restarted after stream end");

  // a chunk record only comes out of a finished chunk body
  a_chunk_src: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) && (rec0.record_kind == REC_CHUNK) |-> body_done)
    else $error("chunk record without finished chunk");

endmodule

>>> tb/tb_png_c2pa_chunk_extractor_unit.sv
// self-checking bench for the png credential chunk extractor: random png files go in
// byte by byte and each record is checked against a parse model kept in the bench
// depends on pngc2pa_pkg, pngc2pa_if and the png_c2pa_chunk_extractor_unit rtl
`timescale 1ns / 1ps

module tb_png_c2pa_chunk_extractor_unit;
  import pngc2pa_pkg::*;

  // one file byte as it goes out on the input channel
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  pngc2pa_in_if  in_ch ();
  pngc2pa_out_if out_ch ();

  png_c2pa_chunk_extractor_unit #(.POS_BITS(32)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // parse model state, one copy of everything the walker keeps per file
  // ---------------------------------------------------------------------------
  phase_t        walk_phase;
  logic [3:0]    field_cnt;
  logic [31:0]   byte_pos;
  logic [31:0]   chunk_base;
  logic [31:0]   chunk_len;
  logic [32:0]   left_in_chunk;
  logic [31:0]   chunk_type;
  logic [WIN_W-1:0] scan_win;     // newest byte in the low 8 bits
  logic [3:0]    tokens;          // cr, xpacket, adobe.com/xap, contentauth
  logic          iend_done;
  logic          sig_failed;
  logic          min_seen;        // at least 20 bytes went by

  rec_t          pending_records[$];   // records the block still owes us
  file_byte_t    byte_q[$];            // bytes still to be sent
  logic [7:0]    body_bytes[$];        // data of the chunk being built
  int            errors = 0;

  task automatic reset_parser();
    walk_phase    = PH_SIG;
    field_cnt     = '0;
    byte_pos      = '0;
    chunk_base    = '0;
    chunk_len     = '0;
    left_in_chunk = '0;
    chunk_type    = '0;
    scan_win      = '0;
    tokens        = '0;
    iend_done     = 1'b0;
    sig_failed    = 1'b0;
    min_seen      = 1'b0;
  endtask

  // slide one byte into the token window and latch any word that now ends there
  task automatic shift_window(input logic [7:0] b);
    scan_win = {scan_win[WIN_W-9:0], b};
    if (scan_win[23:0] == TOK_CR) tokens[0] = 1'b1;
    if (scan_win[55:0] == TOK_XP) tokens[1] = 1'b1;
    if (scan_win[103:0] == TOK_AD) tokens[2] = 1'b1;
    if (scan_win[87:0] == TOK_CA) tokens[3] = 1'b1;
  endtask

  // walk one accepted byte and queue the records it causes
  task automatic parse_byte(input logic [7:0] b, input logic eos);
    rec_t    r;
    logic    is_cabx;
    logic    is_itxt;
    status_t st;
    if (byte_pos >= 32'd19) min_seen = 1'b1;
    case (walk_phase)
      PH_SIG: begin
        if (b != SIG_BYTES[field_cnt[2:0]]) begin
          sig_failed = 1'b1;
          walk_phase = PH_FAIL;
        end else if (field_cnt == 4'd7) begin
          field_cnt  = '0;
          walk_phase = PH_LEN;
        end else begin
          field_cnt = field_cnt + 4'd1;
        end
      end
      PH_LEN: begin
        // first length byte opens a new chunk: window and tokens start over
        if (field_cnt == 4'd0) begin
          scan_win   = '0;
          tokens     = '0;
          chunk_base = byte_pos;
          chunk_len  = '0;
        end
        shift_window(b);
        chunk_len = {chunk_len[23:0], b};
        if (field_cnt == 4'd3) begin
          field_cnt  = '0;
          walk_phase = PH_TYPE;
        end else begin
          field_cnt = field_cnt + 4'd1;
        end
      end
      PH_TYPE: begin
        shift_window(b);
        chunk_type = {chunk_type[23:0], b};
        if (field_cnt == 4'd3) begin
          field_cnt     = '0;
          left_in_chunk = {1'b0, chunk_len} + 33'd4;   // data plus crc
          walk_phase    = PH_BODY;
        end else begin
          field_cnt = field_cnt + 4'd1;
        end
      end
      PH_BODY: begin
        shift_window(b);
        left_in_chunk = left_in_chunk - 33'd1;
        if (left_in_chunk == '0) begin
          is_cabx = (chunk_type == TYPE_CABX);
          is_itxt = (chunk_type == TYPE_ITXT) && tokens[0] && (tokens[3:1] != '0);
          if (is_cabx || is_itxt) begin
            r.record_kind  = REC_CHUNK;
            r.chunk_offset = chunk_base;
            r.data_length  = chunk_len;
            r.carrier_kind = is_itxt ? CAR_ITXT : CAR_CABX;
            r.status       = ST_OK;
            r.last_result  = 1'b0;
            pending_records.insert(pending_records.size(), r);
          end
          if (chunk_type == TYPE_IEND) begin
            iend_done  = 1'b1;
            walk_phase = PH_DONE;
          end else begin
            field_cnt  = '0;
            walk_phase = PH_LEN;
          end
        end
      end
      default: ;   // done or failed: bytes are dropped
    endcase
    byte_pos = byte_pos + 32'd1;

    if (eos) begin
      if (!min_seen || sig_failed) st = ST_BAD_SIG;
      else if (iend_done)          st = ST_OK;
      else if (walk_phase == PH_BODY) st = ST_TRUNC;
      else                         st = ST_NO_IEND;
      r.record_kind  = REC_STATUS;
      r.chunk_offset = '0;
      r.data_length  = '0;
      r.carrier_kind = CAR_CABX;
      r.status       = st;
      r.last_result  = 1'b1;
      pending_records.insert(pending_records.size(), r);
      reset_parser();   // next byte starts a fresh file
    end
  endtask

  // ---------------------------------------------------------------------------
  // file builders
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    file_byte_t fb;
    fb.value = b;
    fb.last  = 1'b0;
    byte_q.insert(byte_q.size(), fb);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
  endtask

  task automatic mark_last();
    file_byte_t fb;
    fb      = byte_q.pop_back();
    fb.last = 1'b1;
    byte_q.insert(byte_q.size(), fb);
  endtask

  task automatic put_signature(input int bad_at);
    for (int i = 0; i < 8; i++)
      put_byte(i == bad_at ? SIG_BYTES[i] ^ 8'($urandom_range(1, 255)) : SIG_BYTES[i]);
  endtask

  // length, type, the data in body_bytes, then a random crc
  task automatic put_chunk(input logic [31:0] ctype);
    put_word(32'(body_bytes.size()));
    put_word(ctype);
    foreach (body_bytes[i]) put_byte(body_bytes[i]);
    put_word($urandom);
  endtask

  task automatic add_filler(input int n);
    repeat (n) body_bytes.insert(body_bytes.size(), 8'($urandom));
  endtask

  task automatic add_text(input logic [103:0] txt, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) body_bytes.insert(body_bytes.size(), txt[8*i +: 8]);
  endtask

  // xmp-like data: usually cr:, often one of the packet words, in either order
  task automatic add_xmp_text();
    int  which;
    logic with_cr;
    logic cr_first;
    with_cr  = ($urandom_range(0, 3) != 0);
    which    = $urandom_range(0, 4);   // 0 or 4: no packet word
    cr_first = $urandom_range(0, 1);
    add_filler($urandom_range(0, 4));
    if (with_cr && cr_first) add_text(TOK_CR, 3);
    add_filler($urandom_range(0, 3));
    case (which)
      1: add_text(TOK_XP, 7);
      2: add_text(TOK_AD, 13);
      3: add_text(TOK_CA, 11);
      default: ;
    endcase
    add_filler($urandom_range(0, 3));
    if (with_cr && !cr_first) add_text(TOK_CR, 3);
    add_filler($urandom_range(0, 4));
  endtask

  task automatic add_random_chunk();
    int          pick;
    logic [31:0] ctype;
    body_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      ctype = TYPE_CABX;
      add_filler($urandom_range(0, 20));
    end else if (pick < 70) begin
      ctype = TYPE_ITXT;
      add_xmp_text();
    end else if (pick < 80) begin
      // one bit off a carrier type, must not be reported
      ctype = ($urandom_range(0, 1) ? TYPE_CABX : TYPE_ITXT) ^ (32'd1 << $urandom_range(0, 31));
      add_xmp_text();
    end else begin
      ctype = $urandom_range(0, 1) ? $urandom : "tEXt";
      if ($urandom_range(0, 1)) add_xmp_text();
      else add_filler($urandom_range(0, 16));
    end
    put_chunk(ctype);
  endtask

  task automatic add_random_file();
    int          roll;
    int          n;
    longint      span;
    logic [31:0] len;
    logic [31:0] ctype;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // short file, mostly a partial signature
      n = $urandom_range(1, 19);
      for (int k = 0; k < n; k++)
        put_byte((k < 8 && $urandom_range(0, 3) != 0) ? SIG_BYTES[k] : 8'($urandom));
    end else begin
      put_signature(roll < 12 ? $urandom_range(0, 7) : -1);
      repeat ($urandom_range(0, 4)) add_random_chunk();
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // proper end, sometimes with data in IEND and junk after it
        body_bytes.delete();
        if ($urandom_range(0, 4) == 0) add_filler($urandom_range(1, 6));
        put_chunk(TYPE_IEND);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
      end else if (roll < 70) begin
        // stop on a chunk boundary, no IEND
      end else if (roll < 88) begin
        // header complete, data or crc cut short
        len = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 24));
        case ($urandom_range(0, 3))
          0: ctype = TYPE_CABX;
          1: ctype = TYPE_ITXT;
          2: ctype = TYPE_IEND;
          default: ctype = $urandom;
        endcase
        put_word(len);
        put_word(ctype);
        span = longint'(len) + 4;
        n = (span > 30) ? $urandom_range(0, 30) : $urandom_range(0, int'(span) - 1);
        repeat (n) put_byte(8'($urandom));
      end else begin
        // cut within the length and type fields of a chunk header
        repeat ($urandom_range(1, 7)) put_byte(8'($urandom));
      end
    end
    mark_last();
  endtask

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  int   calm_timer = 0;
  logic in_calm  = 1'b0;   // no gaps on the sender while set
  logic out_calm = 1'b0;   // no stalls on the receiver while set
  int   in_gap   = 0;
  int   out_gap  = 0;
  logic in_fire  = 1'b0;   // request taken at the last rising edge

  function automatic int pick_gap(input logic calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (calm_timer == 0) begin
      calm_timer <= $urandom_range(100, 400);
      in_calm    <= ($urandom_range(0, 3) == 0);
      out_calm   <= ($urandom_range(0, 3) == 0);
    end else begin
      calm_timer <= calm_timer - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: new byte on the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_fire) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (byte_q.size() > 0) begin
          in_ch.valid         <= 1'b1;
          in_ch.byte_value    <= byte_q[0].value;
          in_ch.end_of_stream <= byte_q[0].last;
          void'(byte_q.pop_front());
          in_gap <= pick_gap(in_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap      <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap      <= pick_gap(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: model every taken byte, check every taken record
  // ---------------------------------------------------------------------------
  rec_t want;

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.byte_value, in_ch.end_of_stream);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_records.size() == 0) begin
          errors++;
          if (errors <= 50)
            $display("%0t: unexpected record, expected none, actual kind %0b status %0d",
                     $time, out_ch.record_kind, out_ch.status);
        end else begin
          want = pending_records.pop_front();
          check_field("record_kind", 32'(want.record_kind), 32'(out_ch.record_kind));
          check_field("chunk_offset", want.chunk_offset, out_ch.chunk_offset);
          check_field("data_length", want.data_length, out_ch.data_length);
          check_field("carrier_kind", 32'(want.carrier_kind), 32'(out_ch.carrier_kind));
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("last_result", 32'(want.last_result), 32'(out_ch.last_result));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.byte_value    = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    reset_parser();

    // a one-byte file of all ones: too short and a bad signature
    put_byte(8'hFF);
    mark_last();
    // the smallest good file, then zero and all-ones bytes after IEND
    put_signature(-1);
    put_word(32'h0000_0000);
    put_word(TYPE_IEND);
    put_word(32'hAE42_6082);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'hFF);
    mark_last();

    while (byte_q.size() < 1575) add_random_file();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && pending_records.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
rtl/core/pngc2pa_pkg.sv
rtl/core/pngc2pa_if.sv
rtl/core/pngc2pa_rec_fifo.sv
rtl/core/png_c2pa_chunk_extractor_unit.sv
tb/tb_png_c2pa_chunk_extractor_unit.sv
